### rtl/suktbl_pkg.sv
package suktbl_pkg;

    localparam int MAJOR_W   = 12;
    localparam int TAG_W     = 16;
    localparam int IDX_W     = 6;
    localparam int CNT_OUT_W = 7;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_READ   = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;
    // any command with the high bit set clears
    localparam int   CMD_CLEAR_BIT = 1;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_WRONG_CLASS = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_FULL        = 3'd3,
        ST_READ_OK     = 3'd4,
        ST_BEYOND      = 3'd5,
        ST_CLEARED     = 3'd6
    } t_status;

    typedef struct packed {
        logic               known;
        logic [TAG_W-1:0]   tag;
        logic [MAJOR_W-1:0] major;
    } t_entry;

    typedef struct packed {
        t_cmd               cmd;
        logic               cls;
        logic [MAJOR_W-1:0] major;
        logic [TAG_W-1:0]   tag;
        logic               known;
        logic [IDX_W-1:0]   idx;
    } t_req;

    typedef struct packed {
        logic gt;   // valid and stored major above offered major
        logic eq;   // valid and stored major equals offered major
        logic hit;  // valid and addressed by the read index
    } t_cell_flags;

    typedef struct packed {
        t_status              status;
        t_entry               ent;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

endpackage

### rtl/sorted_unique_key_table_unit.sv
// A request passes through acceptance, a compare cycle in which every cell checks
// its stored major against the request, and a commit cycle that reduces the cell
// flags, shifts the chain and loads the result register. No new request is taken
// until the commit, which waits while the output register holds a result not yet taken.
// Reset (synchronous, active low) clears the entry count, the class filter and the
// handshake state; entry contents are not reset and are never visible below the count.
module sorted_unique_key_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_class_filter,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] command, [2] device_class
    input  logic [2:0]  s_axis_tuser,
    // [11:0] major_number, [27:12] name_tag, [28] name_present, [34:29] read_index
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status
    output logic [2:0]  m_axis_tuser,
    // [11:0] entry_major, [27:12] entry_name_tag, [28] entry_name_known,
    // [35:29] entry_count
    output logic [39:0] m_axis_tdata
);
    import suktbl_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_CMP    = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_req                r_req;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_filter;
    logic                r_out_valid;
    t_result             r_out;
    t_result             n_out;

    t_entry              cell_ent   [TABLE_DEPTH];
    t_entry              cell_rd    [TABLE_DEPTH];
    t_cell_flags         cell_flags [TABLE_DEPTH];

    logic                in_take;
    logic                commit;
    logic                do_shift;
    logic                any_eq;
    logic                any_hit;
    t_entry              rd_ent;
    t_req                in_req;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign commit        = (r_state == S_COMMIT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        in_req.cmd   = s_axis_tuser[1:0];
        in_req.cls   = s_axis_tuser[2];
        in_req.major = s_axis_tdata[11:0];
        in_req.known = s_axis_tdata[28];
        // a missing name is stored as tag zero
        in_req.tag   = s_axis_tdata[28] ? s_axis_tdata[27:12] : '0;
        in_req.idx   = s_axis_tdata[34:29];
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry left_ent;
        logic   left_gt;
        if (g == 0) begin : g_head
            assign left_ent = '0;
            assign left_gt  = 1'b0;
        end else begin : g_body
            assign left_ent = cell_ent[g-1];
            assign left_gt  = cell_flags[g-1].gt;
        end
        suktbl_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_eval     (r_state == S_CMP),
            .i_shift    (do_shift),
            .i_req      (r_req),
            .i_count    (r_count),
            .i_left_gt  (left_gt),
            .i_left_ent (left_ent),
            .o_ent      (cell_ent[g]),
            .o_rd_ent   (cell_rd[g]),
            .o_flags    (cell_flags[g])
        );
    end

    always_comb begin
        any_eq  = 1'b0;
        any_hit = 1'b0;
        rd_ent  = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            any_eq  = any_eq | cell_flags[k].eq;
            any_hit = any_hit | cell_flags[k].hit;
            rd_ent  = rd_ent | cell_rd[k];
        end
    end

    always_comb begin
        n_count      = r_count;
        do_shift     = 1'b0;
        n_out.ent    = '0;
        n_out.status = ST_CLEARED;
        if (r_req.cmd[CMD_CLEAR_BIT]) begin
            n_count      = '0;
            n_out.status = ST_CLEARED;
        end else if (r_req.cmd == CMD_READ) begin
            if (any_hit) begin
                n_out.status = ST_READ_OK;
                n_out.ent    = rd_ent;
            end else begin
                n_out.status = ST_BEYOND;
            end
        end else if (r_req.cls != r_filter) begin
            n_out.status = ST_WRONG_CLASS;
        end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
            n_out.status = ST_FULL;
        end else if (any_eq) begin
            n_out.status = ST_DUPLICATE;
        end else begin
            n_out.status = ST_INSERTED;
            n_count      = r_count + CNT_W'(1);
            do_shift     = commit;
        end
        n_out.count = CNT_OUT_W'(n_count);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_take) n_state = S_CMP;
            S_CMP:    n_state = S_COMMIT;
            S_COMMIT: if (commit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_filter    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_filter <= i_cfg_class_filter;
            end
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= in_req;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {4'b0, r_out.count, r_out.ent.known, r_out.ent.tag,
                            r_out.ent.major};

endmodule

### rtl/suktbl_cell.sv
module suktbl_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
) (
    input  logic                      i_clk,
    input  logic                      i_eval,
    input  logic                      i_shift,
    input  suktbl_pkg::t_req          i_req,
    input  logic [CNT_W-1:0]          i_count,
    input  logic                      i_left_gt,
    input  suktbl_pkg::t_entry        i_left_ent,
    output suktbl_pkg::t_entry        o_ent,
    output suktbl_pkg::t_entry        o_rd_ent,
    output suktbl_pkg::t_cell_flags   o_flags
);
    import suktbl_pkg::*;

    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    t_entry      r_ent;
    t_entry      n_ent;
    t_cell_flags r_flags;
    t_cell_flags n_flags;
    t_entry      new_ent;
    logic        valid;
    logic        tail;

    assign valid = CNT_W'(CELL_IDX) < i_count;
    assign tail  = CNT_W'(CELL_IDX) == i_count;

    assign new_ent.known = i_req.known;
    assign new_ent.tag   = i_req.tag;
    assign new_ent.major = i_req.major;

    always_comb begin
        n_flags.gt  = valid && (r_ent.major > i_req.major);
        n_flags.eq  = valid && (r_ent.major == i_req.major);
        n_flags.hit = valid && (CMP_W'(i_req.idx) == CMP_W'(CELL_IDX));
    end

    // larger entries move up one place; the gap (or the tail) takes the new entry
    always_comb begin
        n_ent = r_ent;
        if (r_flags.gt || tail) begin
            n_ent = i_left_gt ? i_left_ent : new_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_eval) begin
            r_flags <= n_flags;
        end
        if (i_shift) begin
            r_ent <= n_ent;
        end
    end

    assign o_ent    = r_ent;
    assign o_flags  = r_flags;
    assign o_rd_ent = r_flags.hit ? r_ent : '0;

endmodule
